// ----- sv/cle_pkg.sv -----
`timescale 1ns / 1ps
// Package for the circular list engine: field widths, command and status codes,
// and the cell operation type. Depends on nothing.
package cle_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 16;
    localparam int OCC_W    = 5;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    // Request commands
    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DUMP      = 2'd3;

    // Response status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // What every cell of the row does in a cycle
    typedef enum logic [2:0] {
        OP_HOLD,    // keep value
        OP_PUSH,    // take left neighbour (insert at front)
        OP_WRITE,   // selected cell loads the new value
        OP_PULL,    // cells from the selected one on take right neighbour
        OP_ROTATE   // cells below the selected one take right, selected takes head
    } cell_op_t;

endpackage

// ----- sv/cle_if.sv -----
`timescale 1ns / 1ps
// Request and response channel interfaces of the circular list engine.
// Depends on cle_pkg.
interface cle_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [cle_pkg::CMD_W-1:0]            cmd;
    logic signed [cle_pkg::VALUE_W-1:0]   value;
    logic [cle_pkg::POS_W-1:0]            position;

    modport source (output valid, output cmd, output value, output position, input ready);
    modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

interface cle_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [cle_pkg::STATUS_W-1:0]         status;
    logic signed [cle_pkg::VALUE_W-1:0]   item;
    logic                                 last;
    logic [cle_pkg::OCC_W-1:0]            occupancy;

    modport source (output valid, output status, output item, output last,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input item, input last,
                    input occupancy, output ready);
endinterface

// ----- sv/circular_list_engine_core.sv -----
`timescale 1ns / 1ps
// Top level of the circular list engine: control sequencer and the row of cells.
// Depends on cle_pkg, cle_if (cle_req_if, cle_rsp_if) and cle_cell.
//
// req (sink): one request carries cmd, value and position; cmd selects insert
//   at front, insert at back, delete at a 1-based position, or dump.
// rsp (source): each response carries status, item, last and occupancy. Every
//   command gives one response, except a dump of a non-empty list, which gives
//   one response per entry, head first, with last set on the final one.
// The list sits in list order in a row of DEPTH cells, cell 0 the head; each
//   whole-row move (shift, pull, rotate) updates the cells together.
// Inserts and rejected commands: response registered at accept and shown in the
//   cycle after; the next request may be taken in the cycle the response is shown.
// Delete at position p of n entries: rotations in S_SEEK bring the entry to the
//   head, S_POP removes it and loads the response, rotations in S_RESTORE put
//   the order back; no request is taken until the block is idle again.
// Dump of n entries: one response per cycle through a rotation of the row
//   while the receiver keeps ready high; a waiting response holds the rotation.
// Reset empties the list and clears the response register. A waiting response
//   holds a dump and blocks new requests; delete rotations run on regardless.
module circular_list_engine_core #(
    parameter int DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    cle_req_if.sink      req,
    cle_rsp_if.source    rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEEK,     // rotating target entry towards the head
        S_POP,      // removing the head
        S_RESTORE,  // rotating back to original order
        S_DUMP      // streaming entries out
    } state_t;

    state_t                       state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [IDX_W-1:0]             steps_reg, steps_next;
    logic [IDX_W-1:0]             rest_reg, rest_next;
    logic                         ov_reg, ov_next;
    logic [cle_pkg::STATUS_W-1:0] st_reg, st_next;
    logic [cle_pkg::VALUE_W-1:0]  item_reg, item_next;
    logic                         last_reg, last_next;
    logic [cle_pkg::OCC_W-1:0]    occ_reg, occ_next;

    cle_pkg::cell_op_t            op;
    logic [IDX_W-1:0]             sel;

    logic [cle_pkg::VALUE_W-1:0]  vals_w  [DEPTH];
    logic [cle_pkg::VALUE_W-1:0]  left_w  [DEPTH];
    logic [cle_pkg::VALUE_W-1:0]  right_w [DEPTH];

    logic                         out_free;
    logic                         req_ready;
    logic                         req_take;
    logic [cle_pkg::POS_W-1:0]    count_pos;
    logic [IDX_W-1:0]             last_idx;

    assign out_free  = !ov_reg || rsp.ready;
    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign req_take  = req.valid && req_ready;
    assign count_pos = cle_pkg::POS_W'(count_reg);
    // index of the tail cell; only used while the list is not empty
    assign last_idx  = IDX_W'(count_reg - CNT_ONE);

    // ---------------------------------------------------------------
    // Row of cells
    // ---------------------------------------------------------------
    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_cell
        if (gi == 0)
        begin : g_first
            assign left_w[gi] = req.value;
        end
        else
        begin : g_left
            assign left_w[gi] = vals_w[gi-1];
        end

        if (gi == DEPTH - 1)
        begin : g_end
            assign right_w[gi] = vals_w[gi];
        end
        else
        begin : g_right
            assign right_w[gi] = vals_w[gi+1];
        end

        cle_cell #(
            .IDX_W (IDX_W),
            .IDX   (gi)
        ) u_cell (
            .clk       (clk),
            .op        (op),
            .sel       (sel),
            .left      (left_w[gi]),
            .right     (right_w[gi]),
            .head      (vals_w[0]),
            .new_value (req.value),
            .value     (vals_w[gi])
        );
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        steps_next = steps_reg;
        rest_next  = rest_reg;
        ov_next    = ov_reg && !rsp.ready;
        st_next    = st_reg;
        item_next  = item_reg;
        last_next  = last_reg;
        occ_next   = occ_reg;
        op         = cle_pkg::OP_HOLD;
        sel        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    case (req.cmd)
                        cle_pkg::CMD_INS_FRONT, cle_pkg::CMD_INS_BACK:
                        begin
                            ov_next   = 1'b1;
                            item_next = '0;
                            last_next = 1'b1;
                            if (count_reg >= DEPTH_CNT)
                            begin
                                st_next  = cle_pkg::ST_FULL;
                                occ_next = cle_pkg::OCC_W'(count_reg);
                            end
                            else
                            begin
                                op         = (req.cmd == cle_pkg::CMD_INS_FRONT) ?
                                             cle_pkg::OP_PUSH : cle_pkg::OP_WRITE;
                                sel        = IDX_W'(count_reg);
                                count_next = count_reg + CNT_ONE;
                                st_next    = cle_pkg::ST_OK;
                                occ_next   = cle_pkg::OCC_W'(count_reg + CNT_ONE);
                            end
                        end
                        cle_pkg::CMD_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                ov_next   = 1'b1;
                                st_next   = cle_pkg::ST_EMPTY;
                                item_next = '0;
                                last_next = 1'b1;
                                occ_next  = cle_pkg::OCC_W'(count_reg);
                            end
                            else if (req.position == '0 || req.position > count_pos)
                            begin
                                ov_next   = 1'b1;
                                st_next   = cle_pkg::ST_BADPOS;
                                item_next = '0;
                                last_next = 1'b1;
                                occ_next  = cle_pkg::OCC_W'(count_reg);
                            end
                            else
                            begin
                                steps_next = IDX_W'(req.position - cle_pkg::POS_W'(1));
                                rest_next  = IDX_W'(count_pos - req.position);
                                state_next = (req.position == cle_pkg::POS_W'(1)) ?
                                             S_POP : S_SEEK;
                            end
                        end
                        default:
                        begin
                            // dump
                            if (count_reg == '0)
                            begin
                                ov_next   = 1'b1;
                                st_next   = cle_pkg::ST_EMPTY;
                                item_next = '0;
                                last_next = 1'b1;
                                occ_next  = cle_pkg::OCC_W'(count_reg);
                            end
                            else
                            begin
                                steps_next = last_idx;
                                state_next = S_DUMP;
                            end
                        end
                    endcase
                end
            end
            S_SEEK:
            begin
                op         = cle_pkg::OP_ROTATE;
                sel        = last_idx;
                steps_next = steps_reg - IDX_W'(1);
                if (steps_reg == IDX_W'(1))
                    state_next = S_POP;
            end
            S_POP:
            begin
                // response register is empty here: nothing loaded since accept
                op         = cle_pkg::OP_PULL;
                sel        = '0;
                count_next = count_reg - CNT_ONE;
                ov_next    = 1'b1;
                st_next    = cle_pkg::ST_OK;
                item_next  = vals_w[0];
                last_next  = 1'b1;
                occ_next   = cle_pkg::OCC_W'(count_reg - CNT_ONE);
                state_next = (rest_reg == '0) ? S_IDLE : S_RESTORE;
            end
            S_RESTORE:
            begin
                op        = cle_pkg::OP_ROTATE;
                sel       = last_idx;
                rest_next = rest_reg - IDX_W'(1);
                if (rest_reg == IDX_W'(1))
                    state_next = S_IDLE;
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    op        = cle_pkg::OP_ROTATE;
                    sel       = last_idx;
                    ov_next   = 1'b1;
                    st_next   = cle_pkg::ST_OK;
                    item_next = vals_w[0];
                    last_next = (steps_reg == '0);
                    occ_next  = cle_pkg::OCC_W'(count_reg);
                    if (steps_reg == '0)
                        state_next = S_IDLE;
                    else
                        steps_next = steps_reg - IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            steps_reg <= '0;
            rest_reg  <= '0;
            ov_reg    <= 1'b0;
            st_reg    <= cle_pkg::ST_OK;
            item_reg  <= '0;
            last_reg  <= 1'b0;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            steps_reg <= steps_next;
            rest_reg  <= rest_next;
            ov_reg    <= ov_next;
            st_reg    <= st_next;
            item_reg  <= item_next;
            last_reg  <= last_next;
            occ_reg   <= occ_next;
        end
    end

    assign req.ready     = req_ready;
    assign rsp.valid     = ov_reg;
    assign rsp.status    = st_reg;
    assign rsp.item      = item_reg;
    assign rsp.last      = last_reg;
    assign rsp.occupancy = occ_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count above depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_take && (req.cmd == cle_pkg::CMD_INS_FRONT || req.cmd == cle_pkg::CMD_INS_BACK)
         && count_reg < DEPTH_CNT) |=> (count_reg == $past(count_reg) + CNT_ONE))
        else $error("insert did not grow the list");

    a_err_item_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != cle_pkg::ST_OK) |-> (rsp.item == '0 && rsp.last))
        else $error("error response with item or without last");

    a_busy_no_req: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req.ready)
        else $error("request taken while a command is in progress");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |=> (count_reg == $past(count_reg) - CNT_ONE && ov_reg))
        else $error("pop did not shrink the list or load a response");
`endif

endmodule

// ----- sv/cle_cell.sv -----
`timescale 1ns / 1ps
// One cell of the list row: holds the value at one list position.
// Depends on cle_pkg.
module cle_cell #(
    parameter int IDX_W = 4,
    parameter int IDX   = 0
) (
    input  logic                          clk,
    input  cle_pkg::cell_op_t             op,
    input  logic [IDX_W-1:0]              sel,
    input  logic [cle_pkg::VALUE_W-1:0]   left,
    input  logic [cle_pkg::VALUE_W-1:0]   right,
    input  logic [cle_pkg::VALUE_W-1:0]   head,
    input  logic [cle_pkg::VALUE_W-1:0]   new_value,
    output logic [cle_pkg::VALUE_W-1:0]   value
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [cle_pkg::VALUE_W-1:0] val_reg;
    logic [cle_pkg::VALUE_W-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        case (op)
            cle_pkg::OP_HOLD:   val_next = val_reg;
            cle_pkg::OP_PUSH:   val_next = left;
            cle_pkg::OP_WRITE:
            begin
                if (MY_IDX == sel)
                    val_next = new_value;
            end
            cle_pkg::OP_PULL:
            begin
                if (MY_IDX >= sel)
                    val_next = right;
            end
            cle_pkg::OP_ROTATE:
            begin
                if (MY_IDX == sel)
                    val_next = head;
                else if (MY_IDX < sel)
                    val_next = right;
            end
            default:            val_next = val_reg;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign value = val_reg;

endmodule

// ----- test/tb_circular_list_engine_core.sv -----
`timescale 1ns / 1ps
// Testbench for circular_list_engine_core: directed and random list requests
// checked against a queue-based model of the list. Depends on cle_pkg and cle_if.
module tb_circular_list_engine_core;

    localparam int LIST_DEPTH      = 16;
    localparam int MAX_REPORTS     = 10;
    localparam int RANDOM_ITEMS    = 400;
    localparam int SEGMENT_LEN     = 30;
    localparam int HOLD_OFF_AFTER  = 120;   // requests accepted before the long hold-off
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;    // longer than a full-list delete or dump

    localparam logic signed [cle_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [cle_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    // Bias of the random requests over one segment
    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} list_mix_t;

    typedef struct packed {
        logic [cle_pkg::STATUS_W-1:0]       status;
        logic signed [cle_pkg::VALUE_W-1:0] item;
        logic                               last;
        logic [cle_pkg::OCC_W-1:0]          occupancy;
    } list_rsp_t;

    // Keeps the list in head-to-tail order and the responses still owed.
    // Slot allocation inside the block does not show at the ports, so the
    // order of values is all that needs tracking.
    class list_tracker;
        logic signed [cle_pkg::VALUE_W-1:0] entries[$];
        list_rsp_t                          owed[$];
        int                                 errors;

        function new();
            errors = 0;
        endfunction

        function int count();
            return entries.size();
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void owe(logic [cle_pkg::STATUS_W-1:0] status,
                          logic signed [cle_pkg::VALUE_W-1:0] item,
                          logic last);
            list_rsp_t r;
            r.status    = status;
            r.item      = item;
            r.last      = last;
            r.occupancy = cle_pkg::OCC_W'(entries.size());
            owed.push_back(r);
        endfunction

        function void note_request(logic [cle_pkg::CMD_W-1:0] cmd,
                                   logic signed [cle_pkg::VALUE_W-1:0] value,
                                   logic [cle_pkg::POS_W-1:0] position);
            int idx;
            logic signed [cle_pkg::VALUE_W-1:0] taken;
            case (cmd)
                cle_pkg::CMD_INS_FRONT, cle_pkg::CMD_INS_BACK:
                begin
                    if (entries.size() >= LIST_DEPTH)
                    begin
                        owe(cle_pkg::ST_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        if (cmd == cle_pkg::CMD_INS_FRONT)
                            entries.push_front(value);
                        else
                            entries.push_back(value);
                        owe(cle_pkg::ST_OK, '0, 1'b1);
                    end
                end
                cle_pkg::CMD_DELETE:
                begin
                    if (entries.size() == 0)
                    begin
                        owe(cle_pkg::ST_EMPTY, '0, 1'b1);
                    end
                    else if (position == '0 || int'(position) > entries.size())
                    begin
                        owe(cle_pkg::ST_BADPOS, '0, 1'b1);
                    end
                    else
                    begin
                        idx   = int'(position) - 1;
                        taken = entries[idx];
                        entries.delete(idx);
                        owe(cle_pkg::ST_OK, taken, 1'b1);
                    end
                end
                default:
                begin
                    if (entries.size() == 0)
                    begin
                        owe(cle_pkg::ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        foreach (entries[i])
                            owe(cle_pkg::ST_OK, entries[i], i == entries.size() - 1);
                    end
                end
            endcase
        endfunction

        function void check_response(list_rsp_t got);
            list_rsp_t want;
            if (owed.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: response with none owed:", $time,
                             " status %0d item %0d last %0d occ %0d",
                             got.status, got.item, got.last, got.occupancy);
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status || got.item !== want.item ||
                got.last !== want.last || got.occupancy !== want.occupancy)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: mismatch: expected status %0d item %0d last %0d occ %0d,",
                             $time, want.status, want.item, want.last, want.occupancy,
                             " got status %0d item %0d last %0d occ %0d",
                             got.status, got.item, got.last, got.occupancy);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   accepted_reqs;

    list_tracker tracker = new();

    cle_req_if req_ch();
    cle_rsp_if rsp_ch();

    circular_list_engine_core #(
        .DEPTH (LIST_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Responses are sampled at the edge, before any register of the block moves
    always @(posedge clk)
    begin : rsp_monitor
        list_rsp_t seen;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen.status    = rsp_ch.status;
            seen.item      = rsp_ch.item;
            seen.last      = rsp_ch.last;
            seen.occupancy = rsp_ch.occupancy;
            tracker.check_response(seen);
        end
    end

    // Receiver: mostly ready, short and long stalls, calm stretches with
    // no stall, and one long hold-off so that the block backs up and
    // stops taking requests while the sender keeps offering.
    initial
    begin : rsp_receiver
        int  hold_left;
        int  calm_left;
        int  r;
        bit  long_done;
        hold_left = 0;
        calm_left = 0;
        long_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (!long_done && accepted_reqs >= HOLD_OFF_AFTER)
            begin
                long_done    = 1'b1;
                hold_left    = HOLD_OFF_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (calm_left > 0)
            begin
                rsp_ch.ready <= 1'b1;
                calm_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                begin
                    calm_left    = $urandom_range(30, 80);
                    rsp_ch.ready <= 1'b1;
                end
                else if (r < 75)
                begin
                    rsp_ch.ready <= 1'b1;
                end
                else
                begin
                    rsp_ch.ready <= 1'b0;
                    hold_left    = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 20);
                end
            end
        end
    end

    // Gap before the next request: mostly none, some short, a few long
    function automatic int idle_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    // Offer one request, wait for the handshake, then idle for the gap.
    // Entered just after a rising edge; valid stays high when no gap follows.
    task automatic send_request(input logic [cle_pkg::CMD_W-1:0] cmd,
                                input logic signed [cle_pkg::VALUE_W-1:0] value,
                                input logic [cle_pkg::POS_W-1:0] position, input int gap);
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= cmd;
        req_ch.value    <= value;
        req_ch.position <= position;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        tracker.note_request(cmd, value, position);
        accepted_reqs++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(input list_mix_t mix, input bit calm);
        int  n;
        int  r;
        int  ins_pct;
        int  del_pct;
        logic [cle_pkg::CMD_W-1:0]          cmd;
        logic signed [cle_pkg::VALUE_W-1:0] value;
        logic [cle_pkg::POS_W-1:0]          position;
        n       = tracker.count();
        ins_pct = (mix == MIX_GROW) ? 70 : (mix == MIX_SHRINK) ? 20 : 45;
        del_pct = (mix == MIX_GROW) ? 20 : (mix == MIX_SHRINK) ? 65 : 40;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            cmd = $urandom_range(0, 1) ? cle_pkg::CMD_INS_BACK : cle_pkg::CMD_INS_FRONT;
        else if (r < ins_pct + del_pct)
            cmd = cle_pkg::CMD_DELETE;
        else
            cmd = cle_pkg::CMD_DUMP;
        // unused fields still carry random content
        r = $urandom_range(0, 99);
        case (r % 10)
            0:       value = (r < 50) ? VAL_MAX : VAL_MIN;
            1:       value = (r < 50) ? 32'sd0 : -32'sd1;
            default: value = $urandom;
        endcase
        r = $urandom_range(0, 99);
        if (cmd != cle_pkg::CMD_DELETE || r >= 92)
            position = cle_pkg::POS_W'($urandom_range(0, 65535));
        else if (r < 76 && n > 0)
            position = cle_pkg::POS_W'($urandom_range(1, n));
        else if (r < 84)
            position = '0;
        else
            position = cle_pkg::POS_W'(n + 1);
        send_request(cmd, value, position, idle_gap(calm));
    endtask

    initial
    begin
        #10_000_000;
        $display("circular_list_engine_core test failed");
        $finish;
    end

    initial
    begin
        list_mix_t mix;
        bit        calm;
        rst_n           <= 1'b0;
        accepted_reqs   = 0;
        req_ch.valid    <= 1'b0;
        req_ch.cmd      <= cle_pkg::CMD_INS_FRONT;
        req_ch.value    <= '0;
        req_ch.position <= '0;
        rsp_ch.ready    <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list cases
        send_request(cle_pkg::CMD_DUMP,      32'sd0,  16'd0, idle_gap(1'b0));
        send_request(cle_pkg::CMD_DELETE,    32'sd0,  16'd1, idle_gap(1'b0));
        send_request(cle_pkg::CMD_DELETE,    32'sd0,  16'd0, idle_gap(1'b0));
        // only entry taken out again
        send_request(cle_pkg::CMD_INS_FRONT, VAL_MAX, 16'd0, idle_gap(1'b0));
        send_request(cle_pkg::CMD_DELETE,    32'sd0,  16'd1, idle_gap(1'b0));
        // build five entries from both ends, extreme values
        send_request(cle_pkg::CMD_INS_BACK,  VAL_MIN, 16'hffff, idle_gap(1'b0));
        send_request(cle_pkg::CMD_INS_FRONT, 32'sd0,  16'd0, idle_gap(1'b0));
        send_request(cle_pkg::CMD_INS_BACK,  -32'sd1, 16'd0, idle_gap(1'b0));
        send_request(cle_pkg::CMD_INS_FRONT, 32'sh5555_5555, 16'h5555, idle_gap(1'b0));
        send_request(cle_pkg::CMD_INS_BACK,  32'shaaaa_aaaa, 16'haaaa, idle_gap(1'b0));
        send_request(cle_pkg::CMD_DUMP,      32'sd0,  16'd0, idle_gap(1'b0));
        // invalid positions: zero, one past the end, far beyond
        send_request(cle_pkg::CMD_DELETE,    32'sd0,  16'd0, idle_gap(1'b0));
        send_request(cle_pkg::CMD_DELETE,    32'sd0,  16'd6, idle_gap(1'b0));
        send_request(cle_pkg::CMD_DELETE,    32'sd0,  16'hffff, idle_gap(1'b0));
        // last position, first, middle
        send_request(cle_pkg::CMD_DELETE,    32'sd0,  16'd5, idle_gap(1'b0));
        send_request(cle_pkg::CMD_DELETE,    32'sd0,  16'd1, idle_gap(1'b0));
        send_request(cle_pkg::CMD_DELETE,    32'sd0,  16'd2, idle_gap(1'b0));
        send_request(cle_pkg::CMD_DUMP,      32'sd0,  16'd0, idle_gap(1'b0));
        // tail removed, then the only entry
        send_request(cle_pkg::CMD_DELETE,    32'sd0,  16'd2, idle_gap(1'b0));
        send_request(cle_pkg::CMD_DELETE,    32'sd0,  16'd1, idle_gap(1'b0));
        send_request(cle_pkg::CMD_DUMP,      32'sd0,  16'd0, idle_gap(1'b0));

        // Random segments; the first one is biased towards growing the list
        mix = MIX_GROW;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % SEGMENT_LEN == 0)
            begin
                if (k > 0)
                    mix = list_mix_t'($urandom_range(0, 2));
                calm = ($urandom_range(0, 3) == 0);
            end
            send_random(mix, calm);
        end
        // Runs of inserts that must hit a full list
        for (int k = 0; k < LIST_DEPTH + 2; k++)
            send_request(k[0] ? cle_pkg::CMD_INS_BACK : cle_pkg::CMD_INS_FRONT, $urandom,
                         cle_pkg::POS_W'($urandom_range(0, 65535)), idle_gap(1'b0));
        send_request(cle_pkg::CMD_DUMP, 32'sd0, 16'd0, idle_gap(1'b0));
        req_ch.valid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("circular_list_engine_core test passed");
        else
            $display("circular_list_engine_core test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/cle_pkg.sv
sv/cle_if.sv
sv/cle_cell.sv
sv/circular_list_engine_core.sv
test/tb_circular_list_engine_core.sv
